### sv/tmd_pkg.sv
package tmd_pkg;

  // fixed field widths
  localparam int PIXEL_BITS     = 8;
  localparam int THR_BITS       = 16;
  localparam int THR_FRAC       = 12;
  localparam int SIDE_BITS      = 3;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 13;
  localparam int WIDTH_CMP_BITS = 13;
  localparam int ROW_BITS       = 12;
  localparam int OUT_COL_BITS   = 10;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int MAX_HEIGHT     = 4096;

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_SIDE   = 5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD,
    CFG_WINDOW_SIDE,
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT
  } cfg_index_t;

  typedef struct packed {
    logic [THR_BITS-1:0]    threshold;
    logic [SIDE_BITS-1:0]   window_side;
    logic [WIDTH_BITS-1:0]  image_width;
    logic [HEIGHT_BITS-1:0] image_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold:    16'd410,
    window_side:  3'd3,
    image_width:  11'd640,
    image_height: 13'd480
  };

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_in;
    logic                  frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0]   pixel_out;
    logic [ROW_BITS-1:0]     out_row;
    logic [OUT_COL_BITS-1:0] out_col;
    logic                    replaced;
    logic                    frame_last;
  } out_item_t;

  // side band that travels next to the median pipeline
  typedef struct packed {
    logic [PIXEL_BITS-1:0]   ctr;
    logic [ROW_BITS-1:0]     row;
    logic [OUT_COL_BITS-1:0] col;
    logic                    last;
  } meta_t;

  // stage load enables for the median unit
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } med_ctl_t;

endpackage

### sv/thresholded_median_denoise.sv
// path: an accepted pixel passes the line store read, the median network and the output register
// throughput: one pixel per cycle while in_stall is low; every bank of the line store is read once per pixel
// and the rank-based median network is pipelined over two register stages
// reset: synchronous, active low; counters and pipeline empty, registers take defaults
// after reset a clearing pass zeroes the line store, with in_stall held high
module thresholded_median_denoise #(
  parameter int MAX_WIDTH = tmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SIDE  = tmd_pkg::DEF_MAX_SIDE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tmd_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tmd_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tmd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [tmd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int CW1     = $clog2(MAX_WIDTH + 1);
  localparam int SLW     = $clog2(MAX_SIDE);
  localparam int SLW1    = SLW + 1;
  localparam int NE      = MAX_SIDE * MAX_SIDE;
  localparam int RKW     = $clog2(NE);
  localparam int ODD_CAP = MAX_SIDE - 1 + (MAX_SIDE % 2);
  localparam int PB      = tmd_pkg::PIXEL_BITS;
  localparam int RB      = tmd_pkg::ROW_BITS;
  localparam int HB      = tmd_pkg::HEIGHT_BITS;
  localparam int SB      = tmd_pkg::SIDE_BITS;
  localparam int SQW     = 2 * SB;
  localparam int WCB     = tmd_pkg::WIDTH_CMP_BITS;
  localparam int OCB     = tmd_pkg::OUT_COL_BITS;
  localparam int LIMW    = tmd_pkg::THR_BITS + PB;

  // configuration registers
  tmd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tmd_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (tmd_pkg::cfg_index_t'(cfg_index))
        tmd_pkg::CFG_THRESHOLD: begin
          cfg_r.threshold <= cfg_data[tmd_pkg::THR_BITS-1:0];
        end
        tmd_pkg::CFG_WINDOW_SIDE: begin
          cfg_r.window_side <= cfg_data[SB-1:0];
        end
        tmd_pkg::CFG_IMAGE_WIDTH: begin
          cfg_r.image_width <= cfg_data[tmd_pkg::WIDTH_BITS-1:0];
        end
        tmd_pkg::CFG_IMAGE_HEIGHT: begin
          cfg_r.image_height <= cfg_data[HB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // pipeline flow control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic ld1, ld2, ld3, ld4;
  logic acc;
  logic lb_busy;

  assign ld4      = !out_valid_r || !out_stall;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1 || lb_busy;
  assign acc      = in_valid && !in_stall;

  // raster position counters, slot_r tracks row modulo MAX_SIDE
  logic [RB-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [SLW-1:0] slot_r, slot_nxt;

  logic [WCB-1:0] width_ext;
  logic [CW1-1:0] w_eff;
  logic [HB-1:0]  h_eff;
  logic [RB-1:0]  r0, r2;
  logic [HB-1:0]  r1, r_inc;
  logic [CW-1:0]  c0, c1;
  logic [CW1-1:0] c_inc;
  logic [SLW-1:0] s0, s1, s2;
  logic           wrap_c;
  logic [SB-1:0]  side_odd;
  logic [SQW-1:0] side_sq;
  logic [SLW-1:0] span0, half0;
  logic [RKW-1:0] target0;
  logic           emit0, last0;
  logic [RB-1:0]  row_o0;
  logic [OCB-1:0] col_o0;

  always_comb begin
    // effective frame size
    width_ext = WCB'(cfg_r.image_width);
    if (width_ext == '0) begin
      w_eff = CW1'(1);
    end else if (width_ext > WCB'(MAX_WIDTH)) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(width_ext);
    end
    if (cfg_r.image_height == '0) begin
      h_eff = HB'(1);
    end else if (cfg_r.image_height > HB'(tmd_pkg::MAX_HEIGHT)) begin
      h_eff = HB'(tmd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg_r.image_height;
    end

    // position of this pixel, with frame start and size wraps
    r0 = in_data.frame_start ? '0 : row_r;
    c0 = in_data.frame_start ? '0 : col_r;
    s0 = in_data.frame_start ? '0 : slot_r;
    wrap_c = (CW1'(c0) >= w_eff);
    if (wrap_c) begin
      c1 = '0;
      r1 = HB'(r0) + HB'(1);
      s1 = (s0 == SLW'(MAX_SIDE - 1)) ? '0 : s0 + SLW'(1);
    end else begin
      c1 = c0;
      r1 = HB'(r0);
      s1 = s0;
    end
    if (r1 >= h_eff) begin
      r2 = '0;
      s2 = '0;
    end else begin
      r2 = RB'(r1);
      s2 = s1;
    end

    // position of the next pixel
    c_inc = CW1'(c1) + CW1'(1);
    r_inc = HB'(r2) + HB'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      if (r_inc >= h_eff) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = RB'(r_inc);
        slot_nxt = (s2 == SLW'(MAX_SIDE - 1)) ? '0 : s2 + SLW'(1);
      end
    end else begin
      col_nxt  = CW'(c_inc);
      row_nxt  = r2;
      slot_nxt = s2;
    end

    // effective window side, odd and capped
    side_odd = cfg_r.window_side;
    if (!side_odd[0]) begin
      side_odd = (side_odd == '0) ? SB'(1) : side_odd - SB'(1);
    end
    if (side_odd > SB'(ODD_CAP)) begin
      side_odd = SB'(ODD_CAP);
    end
    span0   = SLW'(side_odd - SB'(1));
    half0   = span0 >> 1;
    side_sq = SQW'(side_odd) * SQW'(side_odd);
    target0 = RKW'((side_sq - SQW'(1)) >> 1);

    // result flags and center position
    emit0  = (r2 >= RB'(span0)) && (c1 >= CW'(span0));
    last0  = (r2 == RB'(h_eff - HB'(1))) && (CW1'(c1) == (w_eff - CW1'(1)));
    row_o0 = r2 - RB'(half0);
    col_o0 = OCB'(c1 - CW'(half0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (acc) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // line store, read at the current column of every slot
  logic [MAX_SIDE-1:0][PB-1:0] rd_data;

  tmd_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SIDE  (MAX_SIDE)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc),
    .wr_slot (s2),
    .addr    (c1),
    .pixel   (in_data.pixel_in),
    .rd_data (rd_data),
    .busy    (lb_busy)
  );

  // stage 1: pixel and position beside the line store read
  logic [PB-1:0]  pix1_r;
  logic [SLW-1:0] slot1_r, span1_r, half1_r;
  logic [RKW-1:0] target1_r;
  logic           emit1_r, last1_r;
  logic [RB-1:0]  row1_r;
  logic [OCB-1:0] col1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pix1_r    <= in_data.pixel_in;
      slot1_r   <= s2;
      span1_r   <= span0;
      half1_r   <= half0;
      target1_r <= target0;
      emit1_r   <= emit0;
      last1_r   <= last0;
      row1_r    <= row_o0;
      col1_r    <= col_o0;
    end
  end

  // column history: hist_r[k] holds column c-1-k of all slots
  logic [MAX_SIDE-1:0][PB-1:0] hist_r   [MAX_SIDE-1];
  logic [MAX_SIDE-1:0][PB-1:0] hist_nxt [MAX_SIDE];
  logic [NE-1:0][PB-1:0]       win_vals;
  logic [NE-1:0]               win_mask;
  logic [MAX_SIDE-1:0]         bank_in;
  logic [MAX_SIDE-1:0]         colm_in;
  logic [SLW1-1:0]             slot_gap;
  logic [SLW-1:0]              ctr_bank;
  tmd_pkg::meta_t              meta1;

  always_comb begin
    // new column, current pixel bypasses its own slot
    for (int q = 0; q < MAX_SIDE; q++) begin
      hist_nxt[0][q] = (slot1_r == SLW'(q)) ? pix1_r : rd_data[q];
    end
    for (int k = 1; k < MAX_SIDE; k++) begin
      hist_nxt[k] = hist_r[k-1];
    end

    // slots within span rows above the current one, columns within span
    for (int q = 0; q < MAX_SIDE; q++) begin
      if (slot1_r >= SLW'(q)) begin
        slot_gap = SLW1'(slot1_r) - SLW1'(q);
      end else begin
        slot_gap = SLW1'(slot1_r) + SLW1'(MAX_SIDE) - SLW1'(q);
      end
      bank_in[q] = (slot_gap <= SLW1'(span1_r));
    end
    for (int k = 0; k < MAX_SIDE; k++) begin
      colm_in[k] = (SLW'(k) <= span1_r);
    end

    for (int q = 0; q < MAX_SIDE; q++) begin
      for (int k = 0; k < MAX_SIDE; k++) begin
        win_vals[q*MAX_SIDE + k] = hist_nxt[k][q];
        win_mask[q*MAX_SIDE + k] = bank_in[q] && colm_in[k];
      end
    end

    // center pixel of the window
    if (slot1_r >= half1_r) begin
      ctr_bank = slot1_r - half1_r;
    end else begin
      ctr_bank = SLW'(SLW1'(slot1_r) + SLW1'(MAX_SIDE) - SLW1'(half1_r));
    end
    meta1.ctr  = hist_nxt[half1_r][ctr_bank];
    meta1.row  = row1_r;
    meta1.col  = col1_r;
    meta1.last = last1_r;
  end

  always_ff @(posedge clk) begin
    if (v1_r && ld2) begin
      for (int k = 0; k < MAX_SIDE - 1; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
    end
  end

  // stages 2 and 3: median network beside the side band
  tmd_pkg::meta_t    meta2_r, meta3_r;
  tmd_pkg::med_ctl_t med_ctl;
  logic [PB-1:0]     med;

  assign med_ctl.ld_a = ld2;
  assign med_ctl.ld_b = ld3;

  tmd_median #(
    .MAX_SIDE (MAX_SIDE)
  ) u_median (
    .clk      (clk),
    .ctl      (med_ctl),
    .win_vals (win_vals),
    .win_mask (win_mask),
    .target   (target1_r),
    .med      (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld2) begin
        v2_r <= v1_r && emit1_r;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      meta2_r <= meta1;
    end
    if (ld3) begin
      meta3_r <= meta2_r;
    end
  end

  // stage 4: relative deviation test and output register
  logic [PB-1:0]      dev;
  logic [LIMW-1:0]    dev_sh, lim;
  logic               rep;
  tmd_pkg::out_item_t out_nxt, out_r;

  always_comb begin
    dev    = (med > meta3_r.ctr) ? med - meta3_r.ctr : meta3_r.ctr - med;
    dev_sh = LIMW'({dev, {tmd_pkg::THR_FRAC{1'b0}}});
    lim    = LIMW'(cfg_r.threshold) * LIMW'(med);
    rep    = !(dev_sh < lim);
    out_nxt.pixel_out  = rep ? med : meta3_r.ctr;
    out_nxt.out_row    = meta3_r.row;
    out_nxt.out_col    = meta3_r.col;
    out_nxt.replaced   = rep;
    out_nxt.frame_last = meta3_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld4) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4 && v3_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/tmd_line_buf.sv
module tmd_line_buf #(
  parameter int MAX_WIDTH = tmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SIDE  = tmd_pkg::DEF_MAX_SIDE,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int SLW = $clog2(MAX_SIDE)
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          wr_en,
  input  logic [SLW-1:0]                                wr_slot,
  input  logic [CW-1:0]                                 addr,
  input  logic [tmd_pkg::PIXEL_BITS-1:0]                pixel,
  output logic [MAX_SIDE-1:0][tmd_pkg::PIXEL_BITS-1:0]  rd_data,
  output logic                                          busy
);

  logic          clr_busy_r;
  logic [CW-1:0] clr_addr_r;

  // clearing pass after reset, one column of all banks per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + CW'(1);
    end
  end

  assign busy = clr_busy_r;

  // one bank per row slot, all banks read at the same column
  for (genvar g = 0; g < MAX_SIDE; g++) begin : g_bank
    logic [tmd_pkg::PIXEL_BITS-1:0] mem [MAX_WIDTH];
    logic [tmd_pkg::PIXEL_BITS-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (clr_busy_r) begin
        mem[clr_addr_r] <= '0;
      end else if (wr_en && (wr_slot == SLW'(g))) begin
        mem[addr] <= pixel;
      end
      if (wr_en) begin
        rd_r <= mem[addr];
      end
    end

    assign rd_data[g] = rd_r;
  end

endmodule

### sv/tmd_median.sv
module tmd_median #(
  parameter int MAX_SIDE = tmd_pkg::DEF_MAX_SIDE,
  localparam int NE  = MAX_SIDE * MAX_SIDE,
  localparam int RKW = $clog2(NE)
) (
  input  logic                                    clk,
  input  tmd_pkg::med_ctl_t                       ctl,
  input  logic [NE-1:0][tmd_pkg::PIXEL_BITS-1:0]  win_vals,
  input  logic [NE-1:0]                           win_mask,
  input  logic [RKW-1:0]                          target,
  output logic [tmd_pkg::PIXEL_BITS-1:0]          med
);

  logic [NE-1:0][tmd_pkg::PIXEL_BITS-1:0] vals_r;
  logic [NE-1:0]                          mask_r;
  logic [NE-1:0][NE-1:0]                  lt_nxt;
  logic [NE-1:0][NE-1:0]                  lt_r;
  logic [RKW-1:0]                         target_r;
  logic [tmd_pkg::PIXEL_BITS-1:0]         med_nxt;
  logic [tmd_pkg::PIXEL_BITS-1:0]         med_r;

  // pairwise order matrix, ties broken by element position
  always_comb begin
    for (int i = 0; i < NE; i++) begin
      for (int j = 0; j < NE; j++) begin
        lt_nxt[i][j] = win_mask[j] &&
                       ((win_vals[j] < win_vals[i]) ||
                        ((win_vals[j] == win_vals[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_a) begin
      vals_r   <= win_vals;
      mask_r   <= win_mask;
      lt_r     <= lt_nxt;
      target_r <= target;
    end
  end

  // the element whose rank is the middle one is the median
  always_comb begin
    med_nxt = '0;
    for (int i = 0; i < NE; i++) begin
      if (mask_r[i] && (RKW'($countones(lt_r[i])) == target_r)) begin
        med_nxt = med_nxt | vals_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_b) begin
      med_r <= med_nxt;
    end
  end

  assign med = med_r;

endmodule

### sv/tmd_checker.sv
module tmd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tmd_pkg::out_item_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // reset empties the pipeline and starts the clearing pass
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("pipeline not empty or input open after reset");

  // clearing pass outlasts the release of reset
  a_clear_pass: assert property (@(posedge clk)
    $rose(rst_n) |=> in_stall)
    else $error("input accepted before line store cleared");

endmodule

bind thresholded_median_denoise tmd_checker u_tmd_checker (.*);
